/* rtl/itlo_pkg.sv */
// itlo_pkg: shared types, constants and helpers for the in-order to level-order reorder unit
// no dependencies; imported by every module of the block except itlo_ram

package itlo_pkg;

    localparam int MAX_LEVELS        = 6;
    localparam int VALUE_WIDTH       = 32;
    localparam int BUF_DEPTH         = (1 << MAX_LEVELS) - 1;
    localparam int ADDR_W            = $clog2(BUF_DEPTH + 1);
    localparam int LEVEL_W           = 3;
    localparam int CFG_W             = 3;
    localparam int TREE_LEVELS_RESET = 6;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [LEVEL_W-1:0]     level_t;
    typedef logic [ADDR_W:0]        wide_t;

    typedef struct packed {
        level_t levels;
    } job_t;

    typedef struct packed {
        logic run_done;
    } back_status_t;

    typedef struct packed {
        level_t level;
        logic   level_end;
        logic   run_last;
    } out_meta_t;

    typedef struct packed {
        value_t    value;
        out_meta_t meta;
    } out_word_t;

    // zero acts as one level, anything above the maximum is clamped
    function automatic level_t eff_levels(input logic [CFG_W-1:0] cfg);
        level_t lv;
        lv = level_t'(cfg);
        if (lv == '0)
        begin
            lv = level_t'(1);
        end
        if (lv > level_t'(MAX_LEVELS))
        begin
            lv = level_t'(MAX_LEVELS);
        end
        return lv;
    endfunction

    // index of the last in-order word of a tree: 2^lv - 2
    function automatic addr_t last_index(input level_t lv);
        wide_t tmp;
        tmp = wide_t'(1) << lv;
        return addr_t'(tmp - wide_t'(2));
    endfunction

    // 2^sh - 1 truncated to an address
    function automatic addr_t pow2_m1(input level_t sh);
        wide_t tmp;
        tmp = wide_t'(1) << sh;
        return addr_t'(tmp - wide_t'(1));
    endfunction

endpackage

/* rtl/itlo_ram.sv */
// itlo_ram: generic single-write, single-read ram with registered read data
// no dependencies

module itlo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 63
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/itlo_front.sv */
// itlo_front: configuration register, word intake and buffer write side
// depends on itlo_pkg; pushes one job per complete tree into the job queue

module itlo_front
    import itlo_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                node_valid,
    input  value_t              node_value,
    output logic                node_ready,
    output logic                ram_we,
    output addr_t               ram_waddr,
    output value_t              ram_wdata,
    output logic                job_push,
    output job_t                job,
    input  back_status_t        back_stat
);

    logic [CFG_W-1:0] levels_reg;
    addr_t            count_reg;
    addr_t            count_next;
    logic             busy_reg;
    logic             busy_next;
    level_t           lv;
    logic             accept;
    logic             tree_full;

    assign lv         = eff_levels(levels_reg);
    assign node_ready = !busy_reg;
    assign accept     = node_valid && node_ready;
    assign tree_full  = accept && (count_reg == last_index(lv));

    assign ram_we     = accept;
    assign ram_waddr  = count_reg;
    assign ram_wdata  = node_value;
    assign job_push   = tree_full;
    assign job.levels = lv;

    always_comb
    begin
        count_next = count_reg;
        busy_next  = busy_reg;
        if (cfg_we)
        begin
            count_next = '0;
        end
        else if (tree_full)
        begin
            count_next = '0;
        end
        else if (accept)
        begin
            count_next = count_reg + addr_t'(1);
        end
        if (tree_full)
        begin
            busy_next = 1'b1;
        end
        else if (back_stat.run_done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= CFG_W'(TREE_LEVELS_RESET);
            count_reg  <= '0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                levels_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

/* rtl/itlo_job_queue.sv */
// itlo_job_queue: two-entry queue of tree jobs between front and back
// depends on itlo_pkg

module itlo_job_queue
    import itlo_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic empty
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign empty    = (cnt_reg == 2'd0);
    assign head_job = slot_reg[rd_ptr_reg];
    assign do_push  = push && (cnt_reg != 2'd2);
    assign do_pop   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

/* rtl/itlo_back.sv */
// itlo_back: level-order address walk, buffer read and two-entry result queue
// depends on itlo_pkg; reads the buffer ram instantiated at the top level

module itlo_back
    import itlo_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         job_empty,
    input  job_t         job,
    output logic         job_pop,
    output addr_t        ram_raddr,
    input  value_t       ram_rdata,
    output back_status_t back_stat,
    output logic         result_valid,
    input  logic         result_ready,
    output out_word_t    result_word
);

    logic       run_reg;
    level_t     lv_reg;
    level_t     level_reg;
    addr_t      j_reg;
    addr_t      idx_reg;
    logic       pend_reg;
    out_meta_t  pend_meta_reg;
    out_word_t  fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    logic       pop_out;
    logic [2:0] occ;
    logic       issue;
    logic       lend;
    logic       last;
    wide_t      stride;
    out_meta_t  meta;

    assign pop_out      = result_valid && result_ready;
    assign occ          = {1'b0, cnt_reg} + {2'b0, pend_reg};
    assign issue        = run_reg && ((occ < 3'd2) || ((occ == 3'd2) && pop_out));
    assign lend         = (j_reg == pow2_m1(level_reg - level_t'(1)));
    assign last         = lend && (level_reg == lv_reg);
    assign stride       = wide_t'(1) << (lv_reg - level_reg + level_t'(1));
    assign job_pop      = !run_reg && !job_empty;
    assign ram_raddr    = idx_reg;
    assign back_stat.run_done = issue && last;

    assign meta.level     = level_reg;
    assign meta.level_end = lend;
    assign meta.run_last  = last;

    assign result_valid = (cnt_reg != 2'd0);
    assign result_word  = fifo_reg[rd_ptr_reg];

    // result queue payload
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            fifo_reg[wr_ptr_reg] <= '{value: ram_rdata, meta: pend_meta_reg};
        end
        if (issue)
        begin
            pend_meta_reg <= meta;
        end
    end

    // walk counters
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            lv_reg    <= job.levels;
            level_reg <= level_t'(1);
            j_reg     <= '0;
            idx_reg   <= pow2_m1(job.levels - level_t'(1));
        end
        else if (issue && !last)
        begin
            if (lend)
            begin
                level_reg <= level_reg + level_t'(1);
                j_reg     <= '0;
                idx_reg   <= pow2_m1(lv_reg - level_reg - level_t'(1));
            end
            else
            begin
                j_reg   <= j_reg + addr_t'(1);
                idx_reg <= idx_reg + addr_t'(stride);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            pend_reg   <= 1'b0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (job_pop)
            begin
                run_reg <= 1'b1;
            end
            else if (issue && last)
            begin
                run_reg <= 1'b0;
            end
            pend_reg <= issue;
            if (pend_reg)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop_out)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, pend_reg} - {1'b0, pop_out};
        end
    end

endmodule

/* rtl/inorder_to_level_order_reorder_unit.sv */
// inorder_to_level_order_reorder_unit: top level of the in-order to level-order reorder unit
// depends on itlo_pkg, itlo_ram, itlo_front, itlo_job_queue, itlo_back
//
// channel   direction  handshake                     payload
// node      in         node_valid / node_ready       node_value
// result    out        result_valid / result_ready   out_value out_level level_end run_last
// cfg       in         cfg_we (no wait)              cfg_wdata (tree_levels)
//
// each word is written into the buffer as it is accepted; a full tree of 2^L-1 words
// is then read back through the single buffer read port, one word per cycle while the
// result queue has room. intake stalls from the last word of a tree until its last
// buffer read is issued.
// result_ready low only pauses the read walk; no word is dropped.
// reset clears all control state and sets tree_levels to 6; no clearing pass.

module inorder_to_level_order_reorder_unit
    import itlo_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             node_valid,
    output logic             node_ready,
    input  value_t           node_value,
    output logic             result_valid,
    input  logic             result_ready,
    output value_t           out_value,
    output level_t           out_level,
    output logic             level_end,
    output logic             run_last
);

    logic         ram_we;
    addr_t        ram_waddr;
    value_t       ram_wdata;
    addr_t        ram_raddr;
    value_t       ram_rdata;
    logic         job_push;
    job_t         push_job;
    logic         job_pop;
    job_t         head_job;
    logic         job_empty;
    back_status_t back_stat;
    out_word_t    result_word;

    itlo_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    itlo_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .node_valid (node_valid),
        .node_value (node_value),
        .node_ready (node_ready),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .job_push   (job_push),
        .job        (push_job),
        .back_stat  (back_stat)
    );

    itlo_job_queue u_jobs (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head_job (head_job),
        .empty    (job_empty)
    );

    itlo_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_empty    (job_empty),
        .job          (head_job),
        .job_pop      (job_pop),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .back_stat    (back_stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

    assign out_value = result_word.value;
    assign out_level = result_word.meta.level;
    assign level_end = result_word.meta.level_end;
    assign run_last  = result_word.meta.run_last;

endmodule

/* bench/inorder_to_level_order_reorder_unit_tb.sv */
// inorder_to_level_order_reorder_unit_tb: self-checking bench for the reorder unit
// feeds in-order trees at fixed and random tree_levels settings and checks the level-order words
// depends on itlo_pkg and inorder_to_level_order_reorder_unit

module inorder_to_level_order_reorder_unit_tb;
    import itlo_pkg::*;

    typedef struct {
        value_t value;
        level_t level;
        logic   level_end;
        logic   run_last;
    } level_word_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             node_valid = 1'b0;
    logic             node_ready;
    value_t           node_value = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    value_t           out_value;
    level_t           out_level;
    logic             level_end;
    logic             run_last;

    logic [CFG_W-1:0] levels_reg;
    int unsigned      fill_count;
    value_t           inorder_buf [BUF_DEPTH];
    value_t           pending_q [$];
    level_word_t      level_order_q [$];
    level_word_t      head_w;
    int unsigned      errors = 0;
    int unsigned      nodes_sent = 0;
    int unsigned      nodes_queued = 0;
    int unsigned      words_checked = 0;
    int unsigned      trees_done = 0;
    int unsigned      gap_left;
    int unsigned      stall_left;
    bit               calm = 1'b0;

    inorder_to_level_order_reorder_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .node_valid   (node_valid),
        .node_ready   (node_ready),
        .node_value   (node_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_value    (out_value),
        .out_level    (out_level),
        .level_end    (level_end),
        .run_last     (run_last)
    );

    always #5 clk = ~clk;

    // levels in effect for a register value
    function automatic int unsigned tree_depth(input logic [CFG_W-1:0] v);
        int unsigned lv;
        lv = v;
        if (lv == 0)
        begin
            lv = 1;
        end
        if (lv > MAX_LEVELS)
        begin
            lv = MAX_LEVELS;
        end
        return lv;
    endfunction

    task automatic reorder_node(input value_t v);
        int unsigned lv;
        int unsigned total;
        int unsigned stride;
        int unsigned idx;
        int unsigned k;
        int unsigned j;
        level_word_t w;
        lv = tree_depth(levels_reg);
        total = (1 << lv) - 1;
        if (fill_count >= total)
        begin
            fill_count = 0;
        end
        inorder_buf[fill_count] = v;
        fill_count++;
        if (fill_count == total)
        begin
            for (k = 1; k <= lv; k++)
            begin
                stride = 1 << (lv - k + 1);
                idx = stride / 2 - 1;
                for (j = 0; j < (1 << (k - 1)); j++)
                begin
                    w.value = inorder_buf[idx];
                    w.level = level_t'(k);
                    w.level_end = (j == (1 << (k - 1)) - 1);
                    w.run_last = w.level_end && (k == lv);
                    level_order_q.push_back(w);
                    idx += stride;
                end
            end
            fill_count = 0;
            trees_done++;
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            errors++;
        end
    endtask

    // node driver and level-order predictor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_valid <= 1'b0;
            node_value <= '0;
            levels_reg = CFG_W'(TREE_LEVELS_RESET);
            fill_count = 0;
            gap_left = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                levels_reg = cfg_wdata;
                fill_count = 0;
            end
            if (node_valid && node_ready)
            begin
                reorder_node(node_value);
                nodes_sent++;
            end
            if (!node_valid || node_ready)
            begin
                if (gap_left == 0 && !calm && $urandom_range(0, 5) == 0)
                begin
                    gap_left = $urandom_range(1, 4);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    node_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    node_valid <= 1'b1;
                    node_value <= pending_q.pop_front();
                end
                else
                begin
                    node_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (level_order_q.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual value %h level %0d",
                             $time, out_value, out_level);
                    errors++;
                end
                else
                begin
                    head_w = level_order_q.pop_front();
                    check_field("out_value", head_w.value, out_value);
                    check_field("out_level", 32'(head_w.level), 32'(out_level));
                    check_field("level_end", 32'(head_w.level_end), 32'(level_end));
                    check_field("run_last", 32'(head_w.run_last), 32'(run_last));
                end
                words_checked++;
            end
            if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 4);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // let the block drain, then allow for a word still being loaded
    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (pending_q.size() > 0 || node_valid || level_order_q.size() > 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_levels(input logic [CFG_W-1:0] v);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_random(input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0: pending_q.push_back('0);
                1: pending_q.push_back('1);
                default: pending_q.push_back($urandom());
            endcase
        end
        nodes_queued += n;
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned trees;
        int unsigned total;
        int unsigned t;
        logic [CFG_W-1:0] lv_sel;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // partial tree at the reset depth, dropped by the rewrite
        queue_random(5);
        set_levels(3'd1);
        pending_q.push_back(32'h0000_0000);
        pending_q.push_back(32'hFFFF_FFFF);
        pending_q.push_back(32'hAAAA_AAAA);
        pending_q.push_back(32'h5555_5555);
        nodes_queued += 4;
        set_levels(3'd0);
        queue_random(1);
        set_levels(3'd2);
        pending_q.push_back(32'd1);
        pending_q.push_back(32'd2);
        pending_q.push_back(32'd3);
        nodes_queued += 3;
        set_levels(3'd3);
        queue_random(4);
        set_levels(3'd2);
        queue_random(3);

        phase = 0;
        while (nodes_queued < 460)
        begin
            if (phase == 0)
            begin
                lv_sel = 3'd6;
            end
            else if (phase == 1)
            begin
                lv_sel = 3'd7;
            end
            else
            begin
                lv_sel = CFG_W'($urandom_range(0, 7));
            end
            set_levels(lv_sel);
            if (nodes_queued > 380)
            begin
                calm = 1'b1;
            end
            total = (1 << tree_depth(lv_sel)) - 1;
            trees = $urandom_range(1, 3);
            for (t = 0; t < trees && nodes_queued < 460; t++)
            begin
                queue_random(total);
            end
            // broken tree, thrown away by the next rewrite
            if (total > 1 && nodes_queued < 460 && $urandom_range(0, 3) == 0)
            begin
                queue_random($urandom_range(1, total - 1));
            end
            phase++;
        end

        wait_idle();
        repeat (16) @(negedge clk);
        $display("covered %0d nodes in %0d complete trees, %0d level-order words checked",
                 nodes_sent, trees_done, words_checked);
        $display("tree_levels 0 through 7, mid-tree rewrites, random stalls on both sides");
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
